// File: src/sfr_pkg.sv
package sfr_pkg;

    localparam int SFR_BUFFER_BYTES = 128;

    localparam logic [7:0] SYNC_FIRST  = 8'hAA;
    localparam logic [7:0] SYNC_SECOND = 8'h77;
    localparam logic [7:0] FLAG_NORMAL = 8'h00;

    // Byte positions within the frame header.
    localparam int POS_SYNC0    = 0;
    localparam int POS_SYNC1    = 1;
    localparam int POS_FLAG     = 2;
    localparam int POS_SUM      = 3;
    localparam int POS_COUNTER  = 4;
    localparam int POS_COMMAND  = 5;
    localparam int POS_ACK      = 6;
    localparam int POS_LENGTH   = 7;
    localparam int HEADER_BYTES = 8;

    // Frame-end compare width: length byte plus header size.
    localparam int CMP_W = 9;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_LVL_W = FIFO_PTR_W + 1;

    typedef enum logic [2:0] {
        KIND_PAYLOAD  = 3'd0,
        KIND_GOOD     = 3'd1,
        KIND_BADSUM   = 3'd2,
        KIND_SYNC0    = 3'd3,
        KIND_SYNC1    = 3'd4,
        KIND_FLAG     = 3'd5,
        KIND_OVERFLOW = 3'd6
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] payload_byte;
        logic [6:0] payload_index;
        logic [7:0] frame_counter;
        logic [7:0] command;
        logic [7:0] ack_byte;
        logic [6:0] length;
        logic       last;
    } result_t;

    typedef struct packed {
        result_t    res0;
        result_t    res1;
        logic [1:0] cnt;
    } parse_out_t;

    typedef struct packed {
        logic [FIFO_LVL_W-1:0] level;
        logic                  room;
    } fifo_status_t;

endpackage

// File: src/serial_frame_receiver_core.sv
// Channel   Handshake             Payload
// rx        rx_valid / rx_ready   rx_byte
// res       res_valid / res_ready kind, payload_byte, payload_index, frame_counter,
//                                 command, ack_byte, length, last
//
// Each received byte is held in an input register and parsed combinationally into
// zero, one or two results, which go into a four-entry result queue.
// With res_ready held high one byte is taken every cycle while the queue has room;
// a byte that yields two results leaves through the single output port one at a time.
// Reset clears the parser to hunt for the first sync byte and empties the queue.
// The input register stalls while the queue has fewer than two free entries.
module serial_frame_receiver_core
    import sfr_pkg::*;
#(
    parameter int BUFFER_BYTES = SFR_BUFFER_BYTES
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rx_valid,
    output logic       rx_ready,
    input  logic [7:0] rx_byte,
    output logic       res_valid,
    input  logic       res_ready,
    output logic [2:0] kind,
    output logic [7:0] payload_byte,
    output logic [6:0] payload_index,
    output logic [7:0] frame_counter,
    output logic [7:0] command,
    output logic [7:0] ack_byte,
    output logic [6:0] length,
    output logic       last
);

    logic         s1_valid_reg;
    logic [7:0]   s1_data_reg;
    logic         s1_fire;
    parse_out_t   parse;
    result_t      head;
    fifo_status_t status;

    assign s1_fire  = s1_valid_reg && status.room;
    assign rx_ready = !s1_valid_reg || s1_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (rx_valid && rx_ready)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_valid && rx_ready)
        begin
            s1_data_reg <= rx_byte;
        end
    end

    sfr_parser #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (s1_fire),
        .data  (s1_data_reg),
        .parse (parse)
    );

    sfr_res_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (s1_fire),
        .parse      (parse),
        .pop_ready  (res_ready),
        .head_valid (res_valid),
        .head       (head),
        .status     (status)
    );

    assign kind          = head.kind;
    assign payload_byte  = head.payload_byte;
    assign payload_index = head.payload_index;
    assign frame_counter = head.frame_counter;
    assign command       = head.command;
    assign ack_byte      = head.ack_byte;
    assign length        = head.length;
    assign last          = head.last;

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        status.level <= FIFO_LVL_W'(FIFO_DEPTH))
        else $error("result queue level above its depth");

    a_verdict_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && kind != KIND_PAYLOAD |-> last)
        else $error("verdict or error transfer not marked last");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && parse.cnt != 2'd0 |=> res_valid)
        else $error("parsed result did not reach the output");

    a_stall_holds_byte: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_fire |=> s1_valid_reg && $stable(s1_data_reg))
        else $error("stalled input byte lost");

endmodule

// File: src/sfr_parser.sv
module sfr_parser
    import sfr_pkg::*;
#(
    parameter int BUFFER_BYTES = SFR_BUFFER_BYTES
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  logic [7:0] data,
    output parse_out_t parse
);

    localparam int PW = $clog2(BUFFER_BYTES);

    logic [PW-1:0]    pos_reg, pos_next;
    logic [7:0]       sum_reg, sum_next;
    logic [7:0]       counter_reg, counter_next;
    logic [7:0]       command_reg, command_next;
    logic [7:0]       ack_reg, ack_next;
    logic [7:0]       length_reg, length_next;
    logic [7:0]       xor_reg, xor_next;
    logic [CMP_W-1:0] pos_inc;
    logic             payload_hit;
    logic             frame_end;
    result_t          pay_res;
    result_t          verdict_res;

    always_comb
    begin
        pos_next     = pos_reg;
        sum_next     = sum_reg;
        counter_next = counter_reg;
        command_next = command_reg;
        ack_next     = ack_reg;
        length_next  = length_reg;
        xor_next     = xor_reg;
        pos_inc      = CMP_W'(pos_reg) + CMP_W'(1);
        payload_hit  = 1'b0;
        frame_end    = 1'b0;
        pay_res      = '0;
        verdict_res  = '0;
        parse        = '0;

        if (pos_reg >= PW'(BUFFER_BYTES - 1))
        begin
            parse.res0.kind = KIND_OVERFLOW;
            parse.res0.last = 1'b1;
            parse.cnt       = 2'd1;
            pos_next        = '0;
        end
        else if (pos_reg == PW'(POS_SYNC0) && data != SYNC_FIRST)
        begin
            parse.res0.kind = KIND_SYNC0;
            parse.res0.last = 1'b1;
            parse.cnt       = 2'd1;
            pos_next        = '0;
        end
        else if (pos_reg == PW'(POS_SYNC1) && data != SYNC_SECOND)
        begin
            parse.res0.kind = KIND_SYNC1;
            parse.res0.last = 1'b1;
            parse.cnt       = 2'd1;
            pos_next        = '0;
        end
        else if (pos_reg == PW'(POS_FLAG) && data != FLAG_NORMAL)
        begin
            parse.res0.kind = KIND_FLAG;
            parse.res0.last = 1'b1;
            parse.cnt       = 2'd1;
            pos_next        = '0;
        end
        else
        begin
            case (pos_reg)
                PW'(POS_SUM):
                begin
                    sum_next = data;
                end
                PW'(POS_COUNTER):
                begin
                    counter_next = data;
                    xor_next     = FLAG_NORMAL ^ data;
                end
                PW'(POS_COMMAND):
                begin
                    command_next = data;
                    xor_next     = xor_reg ^ data;
                end
                PW'(POS_ACK):
                begin
                    ack_next = data;
                    xor_next = xor_reg ^ data;
                end
                PW'(POS_LENGTH):
                begin
                    length_next = data;
                    xor_next    = xor_reg ^ data;
                end
                default:
                begin
                end
            endcase

            if (pos_reg >= PW'(HEADER_BYTES))
            begin
                payload_hit = 1'b1;
                xor_next    = xor_reg ^ data;
            end

            // A zero-length frame ends on its length byte.
            frame_end = (pos_inc >= CMP_W'(HEADER_BYTES)) &&
                        (pos_inc == CMP_W'(length_next) + CMP_W'(HEADER_BYTES));
            pos_next  = frame_end ? '0 : pos_inc[PW-1:0];

            pay_res.kind          = KIND_PAYLOAD;
            pay_res.payload_byte  = data;
            pay_res.payload_index = 7'(pos_reg - PW'(HEADER_BYTES));

            verdict_res.kind          = (xor_next == sum_next) ? KIND_GOOD : KIND_BADSUM;
            verdict_res.frame_counter = counter_next;
            verdict_res.command       = command_next;
            verdict_res.ack_byte      = ack_next;
            verdict_res.length        = length_next[6:0];
            verdict_res.last          = 1'b1;

            if (payload_hit && frame_end)
            begin
                parse.res0 = pay_res;
                parse.res1 = verdict_res;
                parse.cnt  = 2'd2;
            end
            else if (payload_hit)
            begin
                parse.res0      = pay_res;
                parse.res0.last = 1'b1;
                parse.cnt       = 2'd1;
            end
            else if (frame_end)
            begin
                parse.res0 = verdict_res;
                parse.cnt  = 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            sum_reg     <= '0;
            counter_reg <= '0;
            command_reg <= '0;
            ack_reg     <= '0;
            length_reg  <= '0;
            xor_reg     <= '0;
        end
        else if (fire)
        begin
            pos_reg     <= pos_next;
            sum_reg     <= sum_next;
            counter_reg <= counter_next;
            command_reg <= command_next;
            ack_reg     <= ack_next;
            length_reg  <= length_next;
            xor_reg     <= xor_next;
        end
    end

endmodule

// File: src/sfr_res_fifo.sv
module sfr_res_fifo
    import sfr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  parse_out_t   parse,
    input  logic         pop_ready,
    output logic         head_valid,
    output result_t      head,
    output fifo_status_t status
);

    result_t               entries [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_LVL_W-1:0] level_reg, level_next;
    logic [FIFO_LVL_W-1:0] push_cnt;
    logic                  pop;

    assign head_valid   = (level_reg != '0);
    assign head         = entries[rd_ptr_reg];
    assign pop          = head_valid && pop_ready;
    // Room for the worst case of two results from one byte.
    assign status.room  = (level_reg <= FIFO_LVL_W'(FIFO_DEPTH - 2));
    assign status.level = level_reg;

    always_comb
    begin
        push_cnt    = push ? FIFO_LVL_W'(parse.cnt) : '0;
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(push_cnt);
        rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(pop);
        level_next  = level_reg + push_cnt - FIFO_LVL_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && parse.cnt != 2'd0)
        begin
            entries[wr_ptr_reg] <= parse.res0;
        end
        if (push && parse.cnt == 2'd2)
        begin
            entries[wr_ptr_reg + FIFO_PTR_W'(1)] <= parse.res1;
        end
    end

endmodule
